/* rtl/core/tokh_pkg.sv */
`timescale 1ns / 1ps

package tokh_pkg;

  // Field widths fixed by the interface
  localparam int KIND_W  = 8;
  localparam int AREA_W  = 6;
  localparam int COUNT_W = 32;

  // Walk limits and table size
  localparam int MAX_OPTION_BYTES = 40;
  localparam int KIND_COUNT       = 256;

  // Command queue between parser and counter bank
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Option kinds with fixed meaning, and the smallest legal option length
  localparam logic [KIND_W-1:0] KIND_EOL = 8'd0;
  localparam logic [KIND_W-1:0] KIND_NOP = 8'd1;
  localparam logic [KIND_W-1:0] MIN_OPT_LEN = 8'd2;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_KIND    = 2'd1,
    PH_LEN     = 2'd2,
    PH_BODY    = 2'd3
  } phase_t;

  // One command for the counter bank: bump a counter or read it back
  typedef struct packed {
    logic              is_read;
    logic [KIND_W-1:0] kind;
  } cmd_t;

endpackage

/* rtl/core/tokh_front.sv */
`timescale 1ns / 1ps

module tokh_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [7:0]             option_byte,
  input  logic                   first_byte,
  input  logic [5:0]             area_length,
  input  logic [7:0]             read_kind,
  input  logic                   q_full,
  output logic                   push,
  output tokh_pkg::cmd_t         push_cmd
);
  import tokh_pkg::*;

  phase_t              phase, phase_next;
  logic [AREA_W-1:0]   bytes_left, bytes_left_next;
  logic [AREA_W-1:0]   body_left, body_left_next;
  logic [KIND_W-1:0]   current_kind, current_kind_next;
  logic                nop_counted, nop_counted_next;
  logic                beat;

  assign in_ready = !q_full;
  assign beat     = in_valid && in_ready;

  // Walk state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STOPPED;
      bytes_left   <= '0;
      body_left    <= '0;
      current_kind <= '0;
      nop_counted  <= 1'b0;
    end else begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      body_left    <= body_left_next;
      current_kind <= current_kind_next;
      nop_counted  <= nop_counted_next;
    end
  end

  // Take one item: restart on a first byte, then step the walk; a read item becomes a read command
  always_comb begin
    phase_t            ph;
    logic [AREA_W-1:0] bl;
    logic [AREA_W-1:0] bl_dec;
    logic [AREA_W-1:0] body;
    logic [KIND_W-1:0] ck;
    logic              nop;
    logic              bump;
    logic [KIND_W-1:0] bump_kind;
    logic [KIND_W-1:0] body_len;

    ph        = phase;
    bl        = bytes_left;
    body      = body_left;
    ck        = current_kind;
    nop       = nop_counted;
    bump      = 1'b0;
    bump_kind = current_kind;
    body_len  = option_byte - MIN_OPT_LEN;

    if (first_byte) begin
      bl   = (area_length > AREA_W'(MAX_OPTION_BYTES)) ?
             AREA_W'(MAX_OPTION_BYTES) : area_length;
      nop  = 1'b0;
      body = '0;
      ck   = '0;
      ph   = (area_length != '0) ? PH_KIND : PH_STOPPED;
    end

    bl_dec = bl - AREA_W'(1);

    unique case (ph)
      PH_KIND: begin
        bl = bl_dec;
        if (option_byte == KIND_EOL) begin
          ph = PH_STOPPED;
        end else if (option_byte == KIND_NOP) begin
          if (!nop) begin
            bump      = 1'b1;
            bump_kind = KIND_NOP;
            nop       = 1'b1;
          end
          ph = (bl_dec != '0) ? PH_KIND : PH_STOPPED;
        end else if (bl_dec == '0) begin
          ph = PH_STOPPED;
        end else begin
          ck = option_byte;
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        if (option_byte < MIN_OPT_LEN ||
            {1'b0, option_byte} > ({3'b000, bl} + 9'd1)) begin
          ph = PH_STOPPED;
        end else begin
          bump      = 1'b1;
          bump_kind = ck;
          bl        = bl_dec;
          body      = body_len[AREA_W-1:0];
          if (body_len != '0) begin
            ph = PH_BODY;
          end else begin
            ph = (bl_dec != '0) ? PH_KIND : PH_STOPPED;
          end
        end
      end
      PH_BODY: begin
        if (bl != '0) begin
          bl = bl_dec;
        end
        if (body != '0) begin
          body = body - AREA_W'(1);
        end
        if (body == '0) begin
          ph = (bl != '0) ? PH_KIND : PH_STOPPED;
        end
      end
      PH_STOPPED: begin
      end
      default: begin
        ph = PH_STOPPED;
      end
    endcase

    // Hold state on idle cycles and read beats
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    body_left_next    = body_left;
    current_kind_next = current_kind;
    nop_counted_next  = nop_counted;
    push              = 1'b0;
    push_cmd.is_read  = 1'b1;
    push_cmd.kind     = read_kind;

    if (beat) begin
      if (op == OP_READ) begin
        push = 1'b1;
      end else begin
        phase_next        = ph;
        bytes_left_next   = bl;
        body_left_next    = body;
        current_kind_next = ck;
        nop_counted_next  = nop;
        push              = bump;
        push_cmd.is_read  = 1'b0;
        push_cmd.kind     = bump_kind;
      end
    end
  end

  // Walk never holds more bytes than the area allows
  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= AREA_W'(MAX_OPTION_BYTES))
    else $error("bytes_left above area limit");

  // Body bytes are pending only while skipping a body
  a_body_phase: assert property (@(posedge clk) disable iff (rst)
    body_left != '0 |-> phase == PH_BODY)
    else $error("body_left set outside body phase");

endmodule

/* rtl/core/tokh_queue.sv */
`timescale 1ns / 1ps

module tokh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tokh_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           empty,
  output logic           full,
  output tokh_pkg::cmd_t head
);
  import tokh_pkg::*;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QUEUE_AW+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

/* rtl/core/tokh_back.sv */
`timescale 1ns / 1ps

module tokh_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  tokh_pkg::cmd_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tokh_pkg::COUNT_W-1:0] kind_count,
  output logic [tokh_pkg::KIND_W-1:0]  kind_echo
);
  import tokh_pkg::*;

  logic [COUNT_W-1:0] mem [KIND_COUNT];
  logic [KIND_COUNT-1:0] written;

  // Second stage: read data back, update or answer
  logic               s2_valid;
  cmd_t               s2_cmd;
  logic [COUNT_W-1:0] s2_rdata;
  logic               s2_rvalid;
  logic               s2_byp_hit;
  logic [COUNT_W-1:0] s2_byp_data;

  logic               s2_done;
  logic               s2_wr;
  logic               issue;
  logic               out_load;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] wdata;

  // Take the freshest counter value: bypass, stored, or zero if never written
  assign cur   = s2_byp_hit ? s2_byp_data : (s2_rvalid ? s2_rdata : '0);
  assign wdata = (cur == '1) ? cur : cur + COUNT_W'(1);

  assign out_load = s2_valid && s2_cmd.is_read && (!out_valid || out_ready);
  assign s2_done  = !(s2_valid && s2_cmd.is_read) || out_load;
  assign s2_wr    = s2_valid && !s2_cmd.is_read;
  assign issue    = !q_empty && (!s2_valid || s2_done);
  assign q_pop    = issue;

  // Counter memory: write back in stage two, read on issue
  always_ff @(posedge clk) begin
    if (s2_wr) begin
      mem[s2_cmd.kind] <= wdata;
    end
    if (issue) begin
      s2_rdata <= mem[q_head.kind];
    end
  end

  // Written marks stand in for clearing the counters at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (s2_wr) begin
      written[s2_cmd.kind] <= 1'b1;
    end
  end

  // Stage-two payload and bypass of the update landing with this read
  always_ff @(posedge clk) begin
    if (issue) begin
      s2_cmd      <= q_head;
      s2_rvalid   <= written[q_head.kind];
      s2_byp_hit  <= s2_wr && (s2_cmd.kind == q_head.kind);
      s2_byp_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (issue) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  // Output register: hold a result until its beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_count <= cur;
      kind_echo  <= s2_cmd.kind;
    end
  end

  // A stalled read must not be overtaken by a new issue
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_done) |-> !issue)
    else $error("issue while stage two is stalled");

endmodule

/* rtl/core/tcp_option_kind_histogram.sv */
`timescale 1ns / 1ps

// Channel | Handshake           | Payload
// --------+---------------------+-----------------------------------------------
// in      | in_valid / in_ready | op, option_byte, first_byte, area_length,
//         |                     | read_kind
// out     | out_valid/out_ready | kind_count, kind_echo (one beat per read item)
//
// Takes one item per cycle while in_ready is high; a read result passes through
// the queue, the counter read and the output register before it is valid.
// The counter bank is a two-stage read-modify-write with a read port, a write
// port and a bypass; it retires one command per cycle unless a read stalls.
// Reset is synchronous; counters read as zero right after it through
// per-kind written marks, with no clearing pass.
// A 4-entry command queue sits between parser and counter bank; in_ready drops
// only while it is full, which happens when the output stays stalled.

module tcp_option_kind_histogram (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [7:0]                   option_byte,
  input  logic                         first_byte,
  input  logic [5:0]                   area_length,
  input  logic [7:0]                   read_kind,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tokh_pkg::COUNT_W-1:0] kind_count,
  output logic [tokh_pkg::KIND_W-1:0]  kind_echo
);
  import tokh_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_pop;
  logic q_empty;
  logic q_full;
  cmd_t q_head;

  tokh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .option_byte (option_byte),
    .first_byte  (first_byte),
    .area_length (area_length),
    .read_kind   (read_kind),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  tokh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .empty    (q_empty),
    .full     (q_full),
    .head     (q_head)
  );

  tokh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind_count (kind_count),
    .kind_echo  (kind_echo)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tokh_pkg::*;

  typedef struct packed {
    logic              op;
    logic [7:0]        option_byte;
    logic              first_byte;
    logic [AREA_W-1:0] area_length;
    logic [KIND_W-1:0] read_kind;
  } opt_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] kind_count;
    logic [KIND_W-1:0]  kind_echo;
  } count_reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  wire                 in_ready;
  logic                op = OP_BYTE;
  logic [7:0]          option_byte = '0;
  logic                first_byte = 1'b0;
  logic [AREA_W-1:0]   area_length = '0;
  logic [KIND_W-1:0]   read_kind = '0;
  wire                 out_valid;
  logic                out_ready = 1'b0;
  wire [COUNT_W-1:0]   kind_count;
  wire [KIND_W-1:0]    kind_echo;

  tcp_option_kind_histogram u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .option_byte (option_byte),
    .first_byte  (first_byte),
    .area_length (area_length),
    .read_kind   (read_kind),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind_count  (kind_count),
    .kind_echo   (kind_echo)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores
  opt_item_t    pending_items[$];
  count_reply_t count_replies[$];
  opt_item_t    cur_item;
  int           err_count = 0;
  int           beats_in = 0;
  int           cycle_cnt = 0;
  int           src_idle = 0;
  int           sink_stall = 0;
  logic         src_next_valid;
  bit           calm_tail = 1'b0;
  bit           mix_reads = 1'b0;
  bit           seg_first;
  int           seg_alen;
  int           kind_pool[8] = '{2, 3, 4, 5, 8, 30, 254, 255};

  // Histogram predictor state
  logic [COUNT_W-1:0] kind_hist[KIND_COUNT];
  logic [AREA_W-1:0]  area_left;
  phase_t             walk_ph;
  logic [KIND_W-1:0]  cur_kind;
  logic [AREA_W-1:0]  skip_left;
  logic               nop_done;

  function automatic void bump_kind(int k);
    if (k < KIND_COUNT && kind_hist[k] != '1) kind_hist[k] = kind_hist[k] + 1'b1;
  endfunction

  // Advance the option walk by one beat; a read beat queues its expected count
  task automatic walk_and_count(input opt_item_t it);
    count_reply_t r;
    int           b;
    int           alen;
    b = it.option_byte;
    if (it.op == OP_READ) begin
      r.kind_count = (it.read_kind < KIND_COUNT) ? kind_hist[it.read_kind] : '0;
      r.kind_echo  = it.read_kind;
      count_replies.insert(count_replies.size(), r);
    end else begin
      if (it.first_byte) begin
        alen = it.area_length;
        if (alen > MAX_OPTION_BYTES) alen = MAX_OPTION_BYTES;
        area_left = AREA_W'(alen);
        nop_done  = 1'b0;
        skip_left = '0;
        cur_kind  = '0;
        walk_ph   = (alen > 0) ? PH_KIND : PH_STOPPED;
      end
      case (walk_ph)
        PH_KIND: begin
          area_left = area_left - 1'b1;
          if (b == KIND_EOL) begin
            walk_ph = PH_STOPPED;
          end else if (b == KIND_NOP) begin
            if (!nop_done) begin
              bump_kind(KIND_NOP);
              nop_done = 1'b1;
            end
            walk_ph = (area_left != 0) ? PH_KIND : PH_STOPPED;
          end else if (area_left == 0) begin
            walk_ph = PH_STOPPED;
          end else begin
            cur_kind = KIND_W'(b);
            walk_ph  = PH_LEN;
          end
        end
        PH_LEN: begin
          // bytes remaining counted from the kind byte is area_left + 1
          if (b < MIN_OPT_LEN || b > int'(area_left) + 1) begin
            walk_ph = PH_STOPPED;
          end else begin
            bump_kind(cur_kind);
            area_left = area_left - 1'b1;
            skip_left = AREA_W'(b - 2);
            if (skip_left != 0) walk_ph = PH_BODY;
            else walk_ph = (area_left != 0) ? PH_KIND : PH_STOPPED;
          end
        end
        PH_BODY: begin
          if (area_left != 0) area_left = area_left - 1'b1;
          if (skip_left != 0) skip_left = skip_left - 1'b1;
          if (skip_left == 0) walk_ph = (area_left != 0) ? PH_KIND : PH_STOPPED;
        end
        default: ;
      endcase
    end
  endtask

  function automatic int pick_kind();
    if ($urandom_range(0, 1) == 0) return kind_pool[$urandom_range(0, 7)];
    return $urandom_range(0, 255);
  endfunction

  task automatic push_read(input int k);
    opt_item_t it;
    it.op          = OP_READ;
    it.option_byte = 8'($urandom_range(0, 255));
    it.first_byte  = 1'($urandom_range(0, 1));
    it.area_length = AREA_W'($urandom_range(0, 63));
    it.read_kind   = KIND_W'(k);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_byte(input int b, input bit first, input int alen);
    opt_item_t it;
    if (mix_reads && $urandom_range(0, 9) == 0) push_read(pick_kind());
    it.op          = OP_BYTE;
    it.option_byte = 8'(b);
    it.first_byte  = first;
    it.area_length = AREA_W'(alen);
    it.read_kind   = KIND_W'($urandom_range(0, 255));
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_seg_byte(input int b);
    push_byte(b, seg_first, seg_alen);
    seg_first = 1'b0;
  endtask

  // One segment: mostly a well-formed option list, sometimes noise
  task automatic gen_segment();
    int  r;
    int  area;
    int  rem;
    int  k;
    int  len;
    bit  bad;
    r = $urandom_range(0, 99);
    if (r < 80) seg_alen = $urandom_range(1, 40);
    else if (r < 90) seg_alen = $urandom_range(41, 63);
    else if (r < 95) seg_alen = 0;
    else seg_alen = $urandom_range(0, 63);
    area = (seg_alen > MAX_OPTION_BYTES) ? MAX_OPTION_BYTES : seg_alen;
    seg_first = 1'b1;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 20))
        push_byte($urandom_range(0, 255), $urandom_range(0, 5) == 0, $urandom_range(0, 63));
    end else if (area == 0) begin
      push_seg_byte($urandom_range(0, 255));
    end else begin
      rem = area;
      while (rem > 0) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          // end of list; the rest is padding the walk ignores
          push_seg_byte(KIND_EOL);
          rem--;
          while (rem > 0) begin
            push_seg_byte($urandom_range(0, 255));
            rem--;
          end
        end else if (r < 24 || (rem == 1 && r < 60)) begin
          push_seg_byte(KIND_NOP);
          rem--;
        end else begin
          k = pick_kind();
          if (k < 2) k = k + 2;
          push_seg_byte(k);
          rem--;
          if (rem > 0) begin
            if (r < 30) len = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                   : $urandom_range(rem + 2, 255);
            else if (r < 40) len = rem + 1;
            else len = $urandom_range(2, (rem + 1 > 10) ? 10 : rem + 1);
            bad = (len < 2 || len > rem + 1);
            push_seg_byte(len);
            rem--;
            if (bad) begin
              while (rem > 0) begin
                push_seg_byte($urandom_range(0, 255));
                rem--;
              end
            end else begin
              repeat (len - 2) begin
                push_seg_byte($urandom_range(0, 255));
                rem--;
              end
            end
          end
        end
      end
    end
    // stray bytes after the area, then up to two reads
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 255), 1'b0, $urandom_range(0, 63));
    repeat ($urandom_range(0, 2)) push_read(pick_kind());
  endtask

  // Input driver: hold each beat until accepted, idle in random bursts
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      src_next_valid = in_valid;
      if (in_valid && in_ready) begin
        walk_and_count(cur_item);
        beats_in++;
        src_next_valid = 1'b0;
      end
      if (!src_next_valid) begin
        if (src_idle != 0) begin
          src_idle--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          op          <= cur_item.op;
          option_byte <= cur_item.option_byte;
          first_byte  <= cur_item.first_byte;
          area_length <= cur_item.area_length;
          read_kind   <= cur_item.read_kind;
          src_next_valid = 1'b1;
          calm_tail = pending_items.size() < 200;
          if (!calm_tail && (beats_in / 150) % 3 != 2 && $urandom_range(0, 7) == 0)
            src_idle = $urandom_range(1, 9);
        end
      end
      in_valid <= src_next_valid;
    end
  end

  // Result monitor: check each beat against the oldest expected count
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      cycle_cnt++;
      if (out_valid && out_ready) begin
        if (count_replies.size() == 0) begin
          err_count++;
          if (err_count <= 40)
            $display("%0t: unexpected result kind_count=%0d kind_echo=%0d",
                     $time, kind_count, kind_echo);
        end else begin
          count_reply_t exp_r;
          exp_r = count_replies.pop_front();
          if (kind_count !== exp_r.kind_count) begin
            err_count++;
            if (err_count <= 40)
              $display("%0t: kind_count expected %0d actual %0d (kind %0d)",
                       $time, exp_r.kind_count, kind_count, exp_r.kind_echo);
          end
          if (kind_echo !== exp_r.kind_echo) begin
            err_count++;
            if (err_count <= 40)
              $display("%0t: kind_echo expected %0d actual %0d",
                       $time, exp_r.kind_echo, kind_echo);
          end
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm_tail && (cycle_cnt / 400) % 3 != 1 && $urandom_range(0, 9) == 0)
          sink_stall = $urandom_range(1, 9);
      end
    end
  end

  initial begin
    for (int i = 0; i < KIND_COUNT; i++) kind_hist[i] = '0;
    area_left = '0;
    walk_ph   = PH_STOPPED;
    cur_kind  = '0;
    skip_left = '0;
    nop_done  = 1'b0;

    // Directed: fresh counter, ignored bytes, NOP once per segment, EOL stop
    push_read(0);
    push_byte(2, 1'b0, 8);
    push_byte(2, 1'b1, 0);
    push_byte(KIND_NOP, 1'b1, 8);
    push_byte(KIND_NOP, 1'b0, 0);
    push_byte(2, 1'b0, 0);
    push_byte(4, 1'b0, 0);
    push_byte(8'h05, 1'b0, 0);
    push_byte(8'hB4, 1'b0, 0);
    push_byte(KIND_EOL, 1'b0, 0);
    push_byte(8'hFF, 1'b0, 0);
    push_read(KIND_NOP);
    push_read(2);
    // oversized area, then a length below two
    push_byte(255, 1'b1, 63);
    push_byte(2, 1'b0, 0);
    push_byte(254, 1'b0, 0);
    push_byte(1, 1'b0, 0);
    push_read(255);
    push_read(254);
    // kind on the last byte, length past the area, exact fit
    push_byte(8, 1'b1, 1);
    push_byte(9, 1'b1, 2);
    push_byte(3, 1'b0, 0);
    push_byte(30, 1'b1, 3);
    push_byte(3, 1'b0, 0);
    push_byte(8'hAA, 1'b0, 0);
    push_read(30);
    push_read(8);

    mix_reads = 1'b1;
    while (pending_items.size() < 1300) gen_segment();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (count_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
